// ===== hw/rtl/area_average_line_downsampler_top_macros.svh =====
// assertion macros used by the area average line downsampler rtl
`ifndef AREA_AVERAGE_LINE_DOWNSAMPLER_TOP_MACROS_SVH
`define AREA_AVERAGE_LINE_DOWNSAMPLER_TOP_MACROS_SVH

// condition holds at every clock edge out of reset
`define AALD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// consequence holds in the same cycle as the trigger
`define AALD_ASSERT_NOW(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |-> (cond)) else $error(msg);

// consequence holds in the cycle after the trigger
`define AALD_ASSERT_NEXT(label, trig, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (trig) |=> (cond)) else $error(msg);

`endif

// ===== hw/rtl/aald_pkg.sv =====
// types, constants and helpers for the area average line downsampler
`timescale 1ns / 1ps

package aald_pkg;

    localparam int PIX_W            = 8;
    localparam int WGT_W            = 13;
    localparam int CFG_DATA_W       = 13;
    localparam int CFG_IDX_W        = 2;
    localparam int MAX_LINE_DEFAULT = 4096;
    localparam int NUM_LANES        = 3;
    localparam int Q_W              = 8;
    localparam int DIV_STEPS        = Q_W + 1;
    localparam int CNT_W            = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_IDX_W-1:0]  REG_OLD_SIZE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  REG_NEW_SIZE = CFG_IDX_W'(1);
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET   = CFG_DATA_W'(4096);
    localparam logic [Q_W-1:0]        Q_MAX        = {Q_W{1'b1}};

    localparam int LANE_RED   = 0;
    localparam int LANE_GREEN = 1;
    localparam int LANE_BLUE  = 2;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic             first_of_line;
        logic             last_of_line;
    } pixel_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             line_done;
    } pixel_out_t;

    typedef struct packed {
        logic             accum;
        logic             start;
        logic             fire;
        logic             last;
        logic [WGT_W-1:0] take;
        logic [WGT_W-1:0] left;
        logic [WGT_W-1:0] o;
        logic             div_step;
        logic             div_first;
    } lane_cmd_t;

    typedef struct packed {
        logic [Q_W-1:0] q;
        logic           sat;
    } lane_res_t;

    typedef struct packed {
        logic res_valid;
        logic line_done;
    } ctrl_stat_t;

    // largest usable line length, bounded by the size register width
    function automatic int line_limit(input int max_line);
        int reg_max;
        reg_max = (1 << WGT_W) - 1;
        return (max_line < reg_max) ? max_line : reg_max;
    endfunction

endpackage

// ===== hw/rtl/aald_ctrl.sv =====
// weight tracking, size registers and divider sequencing
`timescale 1ns / 1ps
`include "area_average_line_downsampler_top_macros.svh"

module aald_ctrl #(
    parameter int MAX_LINE = aald_pkg::MAX_LINE_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  aald_pkg::pixel_in_t                 s_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aald_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aald_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                res_ready,
    output aald_pkg::lane_cmd_t                 cmd,
    output aald_pkg::ctrl_stat_t                stat
);

    localparam int WGT_W = aald_pkg::WGT_W;
    localparam int CNT_W = aald_pkg::CNT_W;
    localparam int LIMIT = aald_pkg::line_limit(MAX_LINE);
    localparam logic [WGT_W-1:0] LIMIT_W   = WGT_W'(LIMIT);
    localparam logic [WGT_W-1:0] ONE_W     = WGT_W'(1);
    localparam logic [CNT_W-1:0] CNT_DONE  = CNT_W'(aald_pkg::DIV_STEPS);

    logic [WGT_W-1:0] old_size_reg, new_size_reg;
    logic [WGT_W-1:0] eff_old, eff_new;
    logic [WGT_W-1:0] wn_reg, wn_next, wn_cur;
    logic [WGT_W-1:0] take, left;
    logic             start, emit, fire, accept, res_valid, res_take, div_step;
    logic             busy_reg, busy_next;
    logic             line_done_reg, line_done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            old_size_reg <= aald_pkg::SIZE_RESET;
            new_size_reg <= aald_pkg::SIZE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                aald_pkg::REG_OLD_SIZE: begin
                    old_size_reg <= cfg_data;
                end
                aald_pkg::REG_NEW_SIZE: begin
                    new_size_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (old_size_reg == '0) begin
            eff_old = ONE_W;
        end else if (old_size_reg > LIMIT_W) begin
            eff_old = LIMIT_W;
        end else begin
            eff_old = old_size_reg;
        end
        if (new_size_reg == '0) begin
            eff_new = ONE_W;
        end else if (new_size_reg > eff_old) begin
            eff_new = eff_old;
        end else begin
            eff_new = new_size_reg;
        end
    end

    assign res_valid = busy_reg && (cnt_reg == CNT_DONE);
    assign res_take  = res_valid && res_ready;
    assign div_step  = busy_reg && (cnt_reg != CNT_DONE);
    assign s_ready   = !busy_reg || res_take;
    assign accept    = s_valid && s_ready;

    always_comb begin
        start  = s_data.first_of_line || (wn_reg == '0);
        wn_cur = start ? eff_old : wn_reg;
        emit   = (eff_new >= wn_cur);
        take   = emit ? wn_cur : eff_new;
        left   = emit ? (eff_new - wn_cur) : '0;
        fire   = emit || s_data.last_of_line;

        wn_next        = wn_reg;
        busy_next      = busy_reg;
        cnt_next       = cnt_reg;
        line_done_next = line_done_reg;

        if (accept) begin
            if (s_data.last_of_line) begin
                wn_next = '0;
            end else if (emit) begin
                wn_next = eff_old - left;
            end else begin
                wn_next = wn_cur - eff_new;
            end
        end

        if (accept && fire) begin
            busy_next      = 1'b1;
            cnt_next       = '0;
            line_done_next = s_data.last_of_line;
        end else if (res_take) begin
            busy_next = 1'b0;
        end else if (div_step) begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wn_reg        <= '0;
            busy_reg      <= 1'b0;
            cnt_reg       <= '0;
            line_done_reg <= 1'b0;
        end else begin
            wn_reg        <= wn_next;
            busy_reg      <= busy_next;
            cnt_reg       <= cnt_next;
            line_done_reg <= line_done_next;
        end
    end

    always_comb begin
        cmd.accum     = accept;
        cmd.start     = start;
        cmd.fire      = fire;
        cmd.last      = s_data.last_of_line;
        cmd.take      = take;
        cmd.left      = left;
        cmd.o         = eff_old;
        cmd.div_step  = div_step;
        cmd.div_first = (cnt_reg == '0);
        stat.res_valid = res_valid;
        stat.line_done = line_done_reg;
    end

    `AALD_ASSERT_NEXT(a_fire_starts_div, accept && fire, busy_reg && (cnt_reg == '0), "divider not started")
    `AALD_ASSERT_NEXT(a_div_counts, div_step, busy_reg && (cnt_reg == $past(cnt_reg) + 1'b1), "divider step lost")
    `AALD_ASSERT_ALWAYS(a_weight_bound, wn_reg <= LIMIT_W, "weight needed beyond line limit")
    `AALD_ASSERT_NEXT(a_last_ends_line, accept && s_data.last_of_line, (wn_reg == '0) && busy_reg, "line not closed")

endmodule

// ===== hw/rtl/aald_lane.sv =====
// one color lane: weighted sum and bit-serial rounding divider
`timescale 1ns / 1ps

module aald_lane #(
    parameter int MAX_LINE = aald_pkg::MAX_LINE_DEFAULT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [aald_pkg::PIX_W-1:0]      px,
    input  aald_pkg::lane_cmd_t             cmd,
    output aald_pkg::lane_res_t             res
);

    localparam int PIX_W  = aald_pkg::PIX_W;
    localparam int WGT_W  = aald_pkg::WGT_W;
    localparam int Q_W    = aald_pkg::Q_W;
    localparam int LIMIT  = aald_pkg::line_limit(MAX_LINE);
    localparam int SUM_W  = $clog2(((1 << PIX_W) - 1) * LIMIT + 1);
    localparam int NUM_W  = SUM_W + 2;
    localparam int PROD_W = PIX_W + WGT_W;

    logic [SUM_W-1:0]  sum_reg, sum_next, sum_base, total;
    logic [PROD_W-1:0] prod_take, prod_left;
    logic [NUM_W-1:0]  rem_reg, den_reg;
    logic [Q_W-1:0]    q_reg;
    logic              sat_reg;
    logic              rem_ge;

    always_comb begin
        sum_base  = cmd.start ? '0 : sum_reg;
        prod_take = PROD_W'(px) * PROD_W'(cmd.take);
        prod_left = PROD_W'(px) * PROD_W'(cmd.left);
        total     = sum_base + SUM_W'(prod_take);
        rem_ge    = (rem_reg >= den_reg);
        sum_next  = sum_reg;
        if (cmd.accum) begin
            if (cmd.fire) begin
                sum_next = cmd.last ? '0 : SUM_W'(prod_left);
            end else begin
                sum_next = total;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            sat_reg <= 1'b0;
        end else begin
            sum_reg <= sum_next;
            if (cmd.accum && cmd.fire) begin
                sat_reg <= 1'b0;
            end else if (cmd.div_step && cmd.div_first) begin
                sat_reg <= rem_ge;
            end
        end
    end

    // numerator 2*sum + o, divisor 2*o, first step checks for overflow
    always_ff @(posedge aclk) begin
        if (cmd.accum && cmd.fire) begin
            rem_reg <= (NUM_W'(total) << 1) + NUM_W'(cmd.o);
            den_reg <= NUM_W'(cmd.o) << (Q_W + 1);
            q_reg   <= '0;
        end else if (cmd.div_step) begin
            den_reg <= den_reg >> 1;
            if (!cmd.div_first) begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - den_reg;
                end
                q_reg <= {q_reg[Q_W-2:0], rem_ge};
            end
        end
    end

    always_comb begin
        res.q   = q_reg;
        res.sat = sat_reg;
    end

endmodule

// ===== hw/rtl/aald_merge.sv =====
// merges lane quotients into the output pixel register
`timescale 1ns / 1ps

module aald_merge (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  aald_pkg::ctrl_stat_t                                stat,
    input  aald_pkg::lane_res_t [aald_pkg::NUM_LANES-1:0]       lane_res,
    output logic                                                res_ready,
    output logic                                                m_valid,
    input  logic                                                m_ready,
    output aald_pkg::pixel_out_t                                m_data
);

    localparam int NUM_LANES = aald_pkg::NUM_LANES;
    localparam int Q_W       = aald_pkg::Q_W;

    logic [Q_W-1:0]       chan [NUM_LANES];
    logic                 m_valid_reg, m_valid_next;
    aald_pkg::pixel_out_t m_data_reg;
    logic                 load;

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            chan[i] = lane_res[i].sat ? aald_pkg::Q_MAX : lane_res[i].q;
        end
    end

    assign res_ready = !m_valid_reg || m_ready;
    assign load      = stat.res_valid && res_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_data_reg.red_out   <= chan[aald_pkg::LANE_RED];
            m_data_reg.green_out <= chan[aald_pkg::LANE_GREEN];
            m_data_reg.blue_out  <= chan[aald_pkg::LANE_BLUE];
            m_data_reg.line_done <= stat.line_done;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== hw/rtl/area_average_line_downsampler_top.sv =====
// a completing pixel starts the dividers; their result then loads m_data and m_valid
// throughput: 1 pixel per cycle while no output completes; a completing pixel
// holds s_ready low until the 9-step serial divider of each lane is done and
// its result is taken; the output register frees it as soon as its own result is taken
// reset (aresetn low, synchronous): sizes 4096, no line in progress, output empty
`timescale 1ns / 1ps

module area_average_line_downsampler_top #(
    parameter int MAX_LINE = aald_pkg::MAX_LINE_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  aald_pkg::pixel_in_t                 s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output aald_pkg::pixel_out_t                m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [aald_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [aald_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NUM_LANES = aald_pkg::NUM_LANES;

    aald_pkg::lane_cmd_t                    cmd;
    aald_pkg::ctrl_stat_t                   stat;
    aald_pkg::lane_res_t [NUM_LANES-1:0]    lane_res;
    logic [aald_pkg::PIX_W-1:0]             lane_px [NUM_LANES];
    logic                                   res_ready;

    assign lane_px[aald_pkg::LANE_RED]   = s_data.red_in;
    assign lane_px[aald_pkg::LANE_GREEN] = s_data.green_in;
    assign lane_px[aald_pkg::LANE_BLUE]  = s_data.blue_in;

    aald_ctrl #(
        .MAX_LINE (MAX_LINE)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_ready (res_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        aald_lane #(
            .MAX_LINE (MAX_LINE)
        ) u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .px      (lane_px[i]),
            .cmd     (cmd),
            .res     (lane_res[i])
        );
    end

    aald_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stat      (stat),
        .lane_res  (lane_res),
        .res_ready (res_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
